FILE: sv/mcsf_pkg.sv
// ----------------------------------------------------------------------------
// mcsf_pkg
// shared types, constants and helpers of the midpoint circle span filler
// ----------------------------------------------------------------------------
package mcsf_pkg;

    localparam int MAX_RADIUS  = 63;
    localparam int COORD_WIDTH = 16;
    localparam int MAX_RESULTS = 48;
    localparam int QUEUE_DEPTH = 2;

    localparam int RADIUS_W   = 6;
    localparam int STEP_W     = 6;
    localparam int DECISION_W = 10;
    localparam int COUNT_W    = $clog2(MAX_RESULTS + 1);
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] COORD_MASK = (COORD_WIDTH >= 16) ? 16'hFFFF :
        16'((32'd1 << COORD_WIDTH) - 32'd1);

    typedef struct packed {
        logic signed [15:0] centre_x;
        logic signed [15:0] centre_y;
        logic [5:0]         radius;
        logic [31:0]        colour;
    } request_t;

    typedef struct packed {
        logic signed [15:0] narrow_left;
        logic signed [15:0] narrow_right;
        logic signed [15:0] wide_left;
        logic signed [15:0] wide_right;
        logic signed [15:0] row_top_outer;
        logic signed [15:0] row_top_inner;
        logic signed [15:0] row_bottom_outer;
        logic signed [15:0] row_bottom_inner;
        logic [31:0]        span_colour;
        logic               last_pass;
    } result_t;

    // a circle that will produce spans, radius already saturated
    typedef struct packed {
        logic signed [15:0]  centre_x;
        logic signed [15:0]  centre_y;
        logic [RADIUS_W-1:0] radius;
        logic [31:0]         colour;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } back_state_t;

    function automatic logic signed [15:0] wrap_coord(input logic [15:0] v);
        return signed'(v & COORD_MASK);
    endfunction

endpackage

FILE: sv/mcsf_front.sv
// ----------------------------------------------------------------------------
// mcsf_front
// takes circle requests, saturates the radius and drops empty circles
// ----------------------------------------------------------------------------
module mcsf_front
    import mcsf_pkg::*;
(
    input  logic          start,
    input  request_t      request,
    input  queue_status_t q_status,
    output logic          busy,
    output logic          push,
    output job_t          push_job
);

    logic accept;
    logic [RADIUS_W-1:0] radius_sat;

    always_comb
    begin
        accept = start && !q_status.full;
        if ({1'b0, request.radius} > 7'(MAX_RADIUS))
        begin
            radius_sat = RADIUS_W'(MAX_RADIUS);
        end
        else
        begin
            radius_sat = request.radius;
        end
        // zero radius is taken but yields nothing, so it never enters the queue
        push              = accept && (radius_sat != '0);
        push_job.centre_x = request.centre_x;
        push_job.centre_y = request.centre_y;
        push_job.radius   = radius_sat;
        push_job.colour   = request.colour;
    end

    assign busy = q_status.full;

endmodule

FILE: sv/mcsf_queue.sv
// ----------------------------------------------------------------------------
// mcsf_queue
// short job queue between the request front and the span sequencer
// ----------------------------------------------------------------------------
module mcsf_queue
    import mcsf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  job_t          push_job,
    input  logic          pop,
    output job_t          pop_job,
    output queue_status_t q_status
);

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign pop_job        = entry_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);

endmodule

FILE: sv/mcsf_back.sv
// ----------------------------------------------------------------------------
// mcsf_back
// midpoint circle sequencer, one span group per cycle while a circle is running
// ----------------------------------------------------------------------------
module mcsf_back
    import mcsf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  queue_status_t q_status,
    input  job_t          pop_job,
    output logic          pop,
    output logic          result_strobe,
    output result_t       result
);

    back_state_t state_reg;
    back_state_t state_next;

    logic signed [15:0]            cx_reg;
    logic signed [15:0]            cx_next;
    logic signed [15:0]            cy_reg;
    logic signed [15:0]            cy_next;
    logic [31:0]                   colour_reg;
    logic [31:0]                   colour_next;
    logic [STEP_W-1:0]             sx_reg;
    logic [STEP_W-1:0]             sx_next;
    logic [STEP_W-1:0]             sy_reg;
    logic [STEP_W-1:0]             sy_next;
    logic signed [DECISION_W-1:0]  d_reg;
    logic signed [DECISION_W-1:0]  d_next;
    logic [COUNT_W-1:0]            count_reg;
    logic [COUNT_W-1:0]            count_next;
    logic                          strobe_reg;
    logic                          strobe_next;
    result_t                       result_reg;
    result_t                       result_next;

    logic [15:0]                   sx_ext;
    logic [15:0]                   sy_ext;
    logic signed [DECISION_W-1:0]  sx_d;
    logic signed [DECISION_W-1:0]  sy_d;
    logic                          last;

    always_comb
    begin
        state_next  = state_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        colour_next = colour_reg;
        sx_next     = sx_reg;
        sy_next     = sy_reg;
        d_next      = d_reg;
        count_next  = count_reg;
        strobe_next = 1'b0;
        result_next = result_reg;
        pop         = 1'b0;
        last        = 1'b0;
        sx_ext      = 16'(sx_reg);
        sy_ext      = 16'(sy_reg);
        sx_d        = signed'(DECISION_W'(sx_reg));
        sy_d        = signed'(DECISION_W'(sy_reg));

        case (state_reg)
            BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop         = 1'b1;
                    cx_next     = pop_job.centre_x;
                    cy_next     = pop_job.centre_y;
                    colour_next = pop_job.colour;
                    sx_next     = '0;
                    sy_next     = STEP_W'(pop_job.radius);
                    d_next      = DECISION_W'(3) -
                                  (signed'(DECISION_W'(pop_job.radius)) <<< 1);
                    count_next  = '0;
                    state_next  = BK_RUN;
                end
            end
            BK_RUN:
            begin
                result_next.narrow_left      = wrap_coord(cx_reg - sx_ext);
                result_next.narrow_right     = wrap_coord(cx_reg + sx_ext);
                result_next.wide_left        = wrap_coord(cx_reg - sy_ext);
                result_next.wide_right       = wrap_coord(cx_reg + sy_ext);
                result_next.row_top_outer    = wrap_coord(cy_reg - sy_ext);
                result_next.row_top_inner    = wrap_coord(cy_reg - sx_ext);
                result_next.row_bottom_outer = wrap_coord(cy_reg + sy_ext);
                result_next.row_bottom_inner = wrap_coord(cy_reg + sx_ext);
                result_next.span_colour      = colour_reg;

                if (d_reg < 0)
                begin
                    d_next = d_reg + (sx_d <<< 2) + DECISION_W'(6);
                end
                else
                begin
                    d_next  = d_reg + ((sx_d - sy_d) <<< 2) + DECISION_W'(10);
                    sy_next = sy_reg - 1'b1;
                end
                sx_next    = sx_reg + 1'b1;
                count_next = count_reg + 1'b1;
                last       = (sy_next < sx_next) || (count_next >= COUNT_W'(MAX_RESULTS));

                result_next.last_pass = last;
                strobe_next           = 1'b1;
                if (last)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BK_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        colour_reg <= colour_next;
        sx_reg     <= sx_next;
        sy_reg     <= sy_next;
        d_reg      <= d_next;
        count_reg  <= count_next;
        result_reg <= result_next;
    end

    assign result_strobe = strobe_reg;
    assign result        = result_reg;

endmodule

FILE: sv/midpoint_circle_span_fill.sv
// ----------------------------------------------------------------------------
// midpoint_circle_span_fill
// filled circle span generator using the integer midpoint recurrence
// ----------------------------------------------------------------------------
// for a request taken while the sequencer is idle, the first span group reaches the
//   ports once the sequencer has popped the job and formed and registered the group
// throughput: one span group per cycle while a circle is in the sequencer;
//   between circles the sequencer passes through idle to pop the next job;
//   a two-entry job queue lets requests queue up
// busy is high while the job queue is full; zero-radius requests give nothing
// reset: asynchronous, clears queue, sequencer state and result strobe
module midpoint_circle_span_fill
    import mcsf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  request_t request,
    output logic     busy,
    output logic     result_strobe,
    output result_t  result
);

    queue_status_t q_status;
    logic          push;
    logic          pop;
    job_t          push_job;
    job_t          pop_job;

    mcsf_front u_front (
        .start    (start),
        .request  (request),
        .q_status (q_status),
        .busy     (busy),
        .push     (push),
        .push_job (push_job)
    );

    mcsf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .q_status (q_status)
    );

    mcsf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .pop_job       (pop_job),
        .pop           (pop),
        .result_strobe (result_strobe),
        .result        (result)
    );

    // the sequencer returns to idle after the final pass, so no span group directly follows it
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && result.last_pass |=> !result_strobe)
        else $error("span group right after final pass");

    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> !q_status.empty)
        else $error("job queue both full and empty");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        push && q_status.empty |=> !q_status.empty)
        else $error("queued job lost");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty job queue");

endmodule
